// File: rtl/core/clsrng_pkg.sv
`default_nettype none

package clsrng_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int WARMUP_STEPS = 8;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int Q_W = IDX_W + 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + WARMUP_STEPS);
	localparam int VAL_W = 31;
	localparam int MUL_W = 16;
	localparam int PROD_W = VAL_W + MUL_W;
	localparam int BND_W = VAL_W + 2;

	localparam longint unsigned MOD1_L = 64'd2147483563;
	localparam longint unsigned MOD2_L = 64'd2147483399;
	localparam longint unsigned TOP_L = 64'h8000_0000;

	localparam logic [VAL_W-1:0] MOD1 = VAL_W'(MOD1_L);
	localparam logic [VAL_W-1:0] MOD2 = VAL_W'(MOD2_L);
	localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
	localparam logic [MUL_W-1:0] MUL2 = 16'd40692;
	localparam logic [7:0] FOLD1 = 8'(TOP_L - MOD1_L);
	localparam logic [7:0] FOLD2 = 8'(TOP_L - MOD2_L);
	localparam logic [VAL_W-1:0] WRAP = VAL_W'(MOD1_L - 64'd1);
	localparam logic [VAL_W-1:0] SEED2_RST = 31'd123456789;

	// slot = last / SLOT_DIV via reciprocal, then one correction step
	localparam longint unsigned SLOT_DIV_L = 64'd1 + (MOD1_L - 64'd1) / 64'(TABLE_DEPTH);
	localparam logic [VAL_W-1:0] SLOT_DIV = VAL_W'(SLOT_DIV_L);
	localparam int RECIP_SHIFT = 40;
	localparam longint unsigned RECIP_L = (64'd1 << RECIP_SHIFT) / SLOT_DIV_L;
	localparam int QP_W = RECIP_SHIFT + Q_W;
	localparam logic [QP_W-1:0] RECIP = QP_W'(RECIP_L);

	typedef struct packed {
		logic load_seed;
		logic mul;
		logic step1;
		logic step2;
		logic fill_wr;
		logic [IDX_W-1:0] fill_idx;
		logic fill_last;
		logic slot;
		logic rd;
		logic swap;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

	// p mod m for m = 2^31 - c: fold the high part once, then one subtract
	function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
		input logic [7:0] c, input logic [VAL_W-1:0] m);
		logic [VAL_W:0] s;
		s = {1'b0, p[VAL_W-1:0]} + ({16'd0, p[PROD_W-1:VAL_W]} * {24'd0, c});
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/clsrng_ctrl.sv
`default_nettype none

module clsrng_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_op,
	input  wire clsrng_pkg::dp_sts_t sts,
	output logic                     s_tready,
	output clsrng_pkg::dp_cmd_t      cmd
);
	import clsrng_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SMUL  = 8'b0000_0010,
		ST_SRED  = 8'b0000_0100,
		ST_DMUL  = 8'b0000_1000,
		ST_DRED  = 8'b0001_0000,
		ST_DSLOT = 8'b0010_0000,
		ST_DREAD = 8'b0100_0000,
		ST_DSWAP = 8'b1000_0000
	} state_t;

	state_t st_q, st_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic accept;

	assign s_tready = (st_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		cmd = '0;
		st_nxt = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_seed = s_op;
					st_nxt = s_op ? ST_SMUL : ST_DMUL;
				end
			end
			ST_SMUL: begin
				cmd.mul = 1'b1;
				st_nxt = ST_SRED;
			end
			ST_SRED: begin
				cmd.step1 = 1'b1;
				cmd.fill_wr = (cnt_q < CNT_W'(TABLE_DEPTH));
				cmd.fill_idx = cnt_q[IDX_W-1:0];
				cmd.fill_last = (cnt_q == '0);
				st_nxt = (cnt_q == '0) ? ST_DMUL : ST_SMUL;
			end
			ST_DMUL: begin
				cmd.mul = 1'b1;
				st_nxt = ST_DRED;
			end
			ST_DRED: begin
				cmd.step1 = 1'b1;
				cmd.step2 = 1'b1;
				st_nxt = ST_DSLOT;
			end
			ST_DSLOT: begin
				cmd.slot = 1'b1;
				st_nxt = ST_DREAD;
			end
			ST_DREAD: begin
				cmd.rd = 1'b1;
				st_nxt = ST_DSWAP;
			end
			ST_DSWAP: begin
				if (!sts.out_busy) begin
					cmd.swap = 1'b1;
					st_nxt = ST_IDLE;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (accept && s_op) begin
				cnt_q <= CNT_W'(TABLE_DEPTH + WARMUP_STEPS - 1);
			end else if (cmd.step1 && !cmd.step2 && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/clsrng_dp.sv
`default_nettype none

module clsrng_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire clsrng_pkg::dp_cmd_t cmd,
	input  wire logic [30:0]         seed,
	input  wire logic                m_tready,
	output logic                     m_tvalid,
	output logic [30:0]              result,
	output clsrng_pkg::dp_sts_t      sts
);
	import clsrng_pkg::*;

	logic [VAL_W-1:0] g1_q, g2_q, last_q, out_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic m_valid_q;
	logic [PROD_W-1:0] p1_q, p2_q;
	logic [QP_W-1:0] qp_q;
	logic [Q_W-1:0] q0_q;
	logic [BND_W-1:0] bound_q;
	logic [IDX_W-1:0] slot_q;
	logic [VAL_W-1:0] rd_q;
	logic rd_vld_q;
	logic [VAL_W-1:0] tbl_mem [TABLE_DEPTH];

	logic [VAL_W-1:0] seed_s, red1, red2, tbl_val, res;
	logic [VAL_W:0] diff, wrapped;
	logic [Q_W-1:0] q0_nxt, slot_sum;
	logic slot_hit, mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [VAL_W-1:0] mem_wd;

	assign seed_s = (seed == '0) ? VAL_W'(1) : seed;
	assign red1 = mod_fold(p1_q, FOLD1, MOD1);
	assign red2 = mod_fold(p2_q, FOLD2, MOD2);
	assign q0_nxt = qp_q[RECIP_SHIFT +: Q_W];
	assign slot_hit = ({2'b00, last_q} >= bound_q);
	assign slot_sum = q0_q + Q_W'(slot_hit);

	assign tbl_val = rd_vld_q ? rd_q : '0;
	assign diff = {1'b0, tbl_val} - {1'b0, g2_q};
	assign wrapped = (diff[VAL_W] || diff == '0) ? diff + {1'b0, WRAP} : diff;
	assign res = wrapped[VAL_W-1:0];

	assign mem_we = cmd.fill_wr || cmd.swap;
	assign mem_wa = cmd.fill_wr ? cmd.fill_idx : slot_q;
	assign mem_wd = cmd.fill_wr ? red1 : g1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_q <= VAL_W'(1);
			g2_q <= SEED2_RST;
			last_q <= '0;
			vld_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.load_seed) begin
				g1_q <= seed_s;
				g2_q <= seed_s;
			end else begin
				if (cmd.step1) begin
					g1_q <= red1;
				end
				if (cmd.step2) begin
					g2_q <= red2;
				end
			end
			if (cmd.fill_last) begin
				last_q <= red1;
			end else if (cmd.swap) begin
				last_q <= res;
			end
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			if (cmd.swap) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p1_q <= PROD_W'(g1_q) * PROD_W'(MUL1);
			p2_q <= PROD_W'(g2_q) * PROD_W'(MUL2);
			qp_q <= QP_W'(last_q) * RECIP;
		end
		if (cmd.step2) begin
			q0_q <= q0_nxt;
			bound_q <= BND_W'(q0_nxt + 1'b1) * BND_W'(SLOT_DIV);
		end
		if (cmd.slot) begin
			slot_q <= (slot_sum >= Q_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
				: slot_sum[IDX_W-1:0];
		end
		if (cmd.rd) begin
			rd_vld_q <= vld_q[slot_q];
		end
		if (cmd.swap) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd) begin
			rd_q <= tbl_mem[slot_q];
		end
	end

	assign m_tvalid = m_valid_q;
	assign result = out_q;
	assign sts.out_busy = m_valid_q && !m_tready;

endmodule

`default_nettype wire

// File: rtl/core/combined_lcg_shuffle_rng.sv
// Combined two-generator multiplicative congruential source with a shuffle table.
// Each input transaction yields one output transaction holding a value in
// 1..2147483562. A draw's result becomes valid after the controller walks
// multiply, modular fold, slot select, table read and swap in order; the table memory
// port is used once for read and once for write. Input is taken again in the cycle
// after the swap. A reseed (tuser = 1) first runs TABLE_DEPTH + 8 generator steps
// for the warm-up and table fill, each step passing a multiply state and a fold state.
// Input is taken only between transactions; the finished result waits in the
// output register, and a following draw stalls at its swap until that register
// is free. Seed the block before relying on the sequence.
`default_nettype none

module combined_lcg_shuffle_rng (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero
	input  wire logic        s_tuser,   // [0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [30:0] random_value, [31] zero
);
	import clsrng_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [30:0] result;

	clsrng_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	clsrng_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.seed     (s_tdata[30:0]),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.result   (result),
		.sts      (sts)
	);

	assign m_tdata = {1'b0, result};

`ifndef ASSERT_OFF
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31] == 1'b0) && (m_tdata[30:0] != 31'd0)
			&& (m_tdata[30:0] <= WRAP))
		else $error("result outside 1..2147483562");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again before the transaction finished");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without work in progress");
`endif

endmodule

`default_nettype wire
